/* design/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// Complementary filter attitude package
// Shared item types, datapath command codes, controller states and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_WIDTH_DEF  = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME    = CFG_IDX_W'(1);

  localparam logic [15:0] BLEND_RESET = 16'd62915;
  localparam logic [15:0] STEP_RESET  = 16'd6554;

  localparam int CNT_W      = 5;   // covers up to 32 CORDIC steps
  localparam int ROOT_STEPS = 16;
  localparam int XW         = 35; // CORDIC x/y width
  localparam int ZW         = 26; // CORDIC angle width
  localparam int MA_W       = 34;
  localparam int MB_W       = 24;
  localparam int PW         = MA_W + MB_W;
  localparam int PRESHIFT   = 14;

  localparam logic signed [MB_W-1:0] RAD2DEG_Q16 = 24'sd3754936;
  localparam logic signed [ZW-1:0]   DEG180_Q14  = 26'sd2949120;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_pitch_axis;
    logic signed [15:0] rate_roll_axis;
    logic signed [23:0] baro_height;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] pitch_estimate;
    logic signed [23:0] roll_estimate;
    logic signed [23:0] height_out;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_SQ_X,
    DP_SQ_Z,
    DP_ROOT,
    DP_CRD_ROLL,
    DP_CRD_PITCH,
    DP_CRD_ITER,
    DP_MUL_RS,
    DP_MUL_RD,
    DP_MUL_WH,
    DP_MUL_WA,
    DP_FUSE,
    DP_WRITE
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             pitch;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Z,
    ST_ROOT,
    ST_ROLL_LOAD,
    ST_ROLL_ITER,
    ST_PITCH_LOAD,
    ST_PITCH_ITER,
    ST_BLEND_PITCH,
    ST_BLEND_ROLL,
    ST_WRITE
  } state_e;

  // atan(2^-i) in Q11.14 degrees
  function automatic logic signed [ZW-1:0] atan_deg(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 26'sd737280;
      5'd1:    r = 26'sd435242;
      5'd2:    r = 26'sd229970;
      5'd3:    r = 26'sd116736;
      5'd4:    r = 26'sd58595;
      5'd5:    r = 26'sd29326;
      5'd6:    r = 26'sd14667;
      5'd7:    r = 26'sd7334;
      5'd8:    r = 26'sd3667;
      5'd9:    r = 26'sd1833;
      5'd10:   r = 26'sd917;
      5'd11:   r = 26'sd458;
      5'd12:   r = 26'sd229;
      5'd13:   r = 26'sd115;
      5'd14:   r = 26'sd57;
      5'd15:   r = 26'sd29;
      5'd16:   r = 26'sd14;
      5'd17:   r = 26'sd7;
      5'd18:   r = 26'sd4;
      5'd19:   r = 26'sd2;
      5'd20:   r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

/* design/complementary_filter_attitude_unit.sv */
// ----------------------------------------------------------------------------
// Complementary filter attitude unit
// Pitch and roll estimation from one IMU sample per item, fixed point.
// ----------------------------------------------------------------------------
// One item is in work at a time, and the sequencer returns to idle after each
// result before the next item can be accepted. The work runs on the shared
// iteration datapath in order: squaring of x and z, a 16-step bit-serial
// square root, two CORDIC vectoring passes (roll then pitch) of CORDIC_STEPS
// iterations each, each pass after its own load step, the two blends on one
// shared multiplier, and the write step.
// The result sits in an output register. The write step waits while the
// previous result there has not been taken; the next item is accepted as
// soon as the current one has been written, even if it is still waiting.
// Configuration writes land at once and must only be issued while the unit
// is idle. Angles are Q9.14 degrees; estimates saturate at a signed
// ANGLE_WIDTH-bit value and the low 24 bits are output.
// ----------------------------------------------------------------------------
module complementary_filter_attitude_unit #(
  parameter int CORDIC_STEPS = cfa_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_WIDTH  = cfa_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cfa_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cfa_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import cfa_pkg::*;

  // command from the sequencer to the datapath, one per cycle
  dp_cmd_t cmd;

  cfa_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  // datapath holds configuration, held estimates and the output register
  cfa_datapath #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_item_o (out_item_o)
  );

endmodule

/* design/cfa_ctrl.sv */
// ----------------------------------------------------------------------------
// Complementary filter attitude controller
// Sequences square, root, two vectoring passes, the blend and the output write.
// ----------------------------------------------------------------------------
module cfa_ctrl #(
  parameter int CORDIC_STEPS = cfa_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cfa_pkg::dp_cmd_t cmd_o
);
  import cfa_pkg::*;

  localparam logic [CNT_W-1:0] CRD_LAST   = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] ROOT_LAST  = CNT_W'(ROOT_STEPS - 1);
  localparam logic [CNT_W-1:0] BLEND_RS   = CNT_W'(0);
  localparam logic [CNT_W-1:0] BLEND_RD   = CNT_W'(1);
  localparam logic [CNT_W-1:0] BLEND_WH   = CNT_W'(2);
  localparam logic [CNT_W-1:0] BLEND_WA   = CNT_W'(3);
  localparam logic [CNT_W-1:0] BLEND_FUSE = CNT_W'(4);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  dp_op_e           blend_op;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cnt_q)
      BLEND_RS:   blend_op = DP_MUL_RS;
      BLEND_RD:   blend_op = DP_MUL_RD;
      BLEND_WH:   blend_op = DP_MUL_WH;
      BLEND_WA:   blend_op = DP_MUL_WA;
      BLEND_FUSE: blend_op = DP_FUSE;
      default:    blend_op = DP_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = ST_SQ_X;
      end
      ST_SQ_X: state_d = ST_SQ_Z;
      ST_SQ_Z: state_d = ST_ROOT;
      ST_ROOT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ROOT_LAST) begin
          cnt_d   = '0;
          state_d = ST_ROLL_LOAD;
        end
      end
      ST_ROLL_LOAD: state_d = ST_ROLL_ITER;
      ST_ROLL_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CRD_LAST) begin
          cnt_d   = '0;
          state_d = ST_PITCH_LOAD;
        end
      end
      ST_PITCH_LOAD: state_d = ST_PITCH_ITER;
      ST_PITCH_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CRD_LAST) begin
          cnt_d   = '0;
          state_d = ST_BLEND_PITCH;
        end
      end
      ST_BLEND_PITCH: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == BLEND_FUSE) begin
          cnt_d   = '0;
          state_d = ST_BLEND_ROLL;
        end
      end
      ST_BLEND_ROLL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == BLEND_FUSE) begin
          cnt_d   = '0;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = DP_IDLE;
    cmd_o.pitch = 1'b0;
    cmd_o.idx   = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      ST_SQ_X:       cmd_o.op = DP_SQ_X;
      ST_SQ_Z:       cmd_o.op = DP_SQ_Z;
      ST_ROOT:       cmd_o.op = DP_ROOT;
      ST_ROLL_LOAD:  cmd_o.op = DP_CRD_ROLL;
      ST_ROLL_ITER:  cmd_o.op = DP_CRD_ITER;
      ST_PITCH_LOAD: cmd_o.op = DP_CRD_PITCH;
      ST_PITCH_ITER: cmd_o.op = DP_CRD_ITER;
      ST_BLEND_PITCH: begin
        cmd_o.op    = blend_op;
        cmd_o.pitch = 1'b1;
      end
      ST_BLEND_ROLL: cmd_o.op = blend_op;
      ST_WRITE: begin
        if (slot_free) begin
          cmd_o.op    = DP_WRITE;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SQ_X))
    else $error("accepted item did not start the square step");

  a_valid_from_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WRITE))
    else $error("result raised outside the write step");

  a_write_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && slot_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("write step did not post a result");

endmodule

/* design/cfa_datapath.sv */
// ----------------------------------------------------------------------------
// Complementary filter attitude datapath
// Shared multiplier, bit-serial root, CORDIC vectoring unit, blend and state.
// ----------------------------------------------------------------------------
module cfa_datapath #(
  parameter int ANGLE_WIDTH = cfa_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfa_pkg::dp_cmd_t             cmd_i,
  input  cfa_pkg::in_item_t            in_item_i,
  input  logic                         cfg_we_i,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output cfa_pkg::out_item_t           out_item_o
);
  import cfa_pkg::*;

  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (ANGLE_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  in_item_t                in_q;
  logic [15:0]             blend_q, step_q;
  logic [31:0]             n_q, root_q;
  logic signed [XW-1:0]    x_q, y_q;
  logic signed [ZW-1:0]    z_q, roll_acc_q;
  logic                    zero_q;
  logic signed [PW-1:0]    prod_q, wh_q;
  logic signed [ANGLE_WIDTH-1:0] pitch_held_q, roll_held_q;
  out_item_t               out_q;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    inc_full;
  logic signed [27:0]      inc;
  logic signed [ANGLE_WIDTH-1:0] held_sel;
  logic signed [ZW-1:0]    acc_sel, pitch_acc;
  logic signed [15:0]      rate_sel;

  // hold the accelerometer angle at zero when both operands were zero
  assign pitch_acc = zero_q ? '0 : z_q;
  assign held_sel  = cmd_i.pitch ? pitch_held_q : roll_held_q;
  assign acc_sel   = cmd_i.pitch ? pitch_acc : roll_acc_q;
  assign rate_sel  = cmd_i.pitch ? in_q.rate_pitch_axis : in_q.rate_roll_axis;
  assign inc_full  = prod_q + (PW'(1) <<< 29);
  assign inc       = inc_full[PW-1:30];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      DP_SQ_X: begin
        mul_a = MA_W'(in_q.accel_x);
        mul_b = MB_W'(in_q.accel_x);
      end
      DP_SQ_Z: begin
        mul_a = MA_W'(in_q.accel_z);
        mul_b = MB_W'(in_q.accel_z);
      end
      DP_MUL_RS: begin
        mul_a = MA_W'(rate_sel);
        mul_b = {8'd0, step_q};
      end
      DP_MUL_RD: begin
        mul_a = prod_q[MA_W-1:0];
        mul_b = RAD2DEG_Q16;
      end
      DP_MUL_WH: begin
        mul_a = MA_W'(held_sel) + MA_W'(inc);
        mul_b = {8'd0, blend_q};
      end
      DP_MUL_WA: begin
        mul_a = MA_W'(acc_sel);
        mul_b = MB_W'(24'd65536 - {8'd0, blend_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // root step
  logic [4:0]  root_sh;
  logic [31:0] root_bit, root_sum;
  assign root_sh  = 5'd30 - {cmd_i.idx[3:0], 1'b0};
  assign root_bit = 32'd1 << root_sh;
  assign root_sum = root_q + root_bit;

  // vectoring load
  logic signed [16:0]    ld_x, ld_y, nx, ny;
  logic signed [ZW-1:0]  ld_z;
  always_comb begin
    if (cmd_i.op == DP_CRD_PITCH) begin
      ld_y = 17'(in_q.accel_y);
      ld_x = $signed(root_q[16:0]);
    end else begin
      ld_y = -17'(in_q.accel_x);
      ld_x = 17'(in_q.accel_z);
    end
    if (ld_x[16]) begin
      ld_z = ld_y[16] ? -DEG180_Q14 : DEG180_Q14;
      nx   = -ld_x;
      ny   = -ld_y;
    end else begin
      ld_z = '0;
      nx   = ld_x;
      ny   = ld_y;
    end
  end

  // vectoring step
  logic signed [XW-1:0] dx, dy;
  assign dx = y_q >>> cmd_i.idx;
  assign dy = x_q >>> cmd_i.idx;

  // blend
  logic signed [SW-1:0] sum, shd, sat;
  always_comb begin
    sum = SW'(wh_q) + SW'(prod_q) + SW'(32768);
    shd = sum >>> 16;
    if (shd > SAT_HI)      sat = SAT_HI;
    else if (shd < SAT_LO) sat = SAT_LO;
    else                   sat = shd;
  end

  logic signed [MA_W-1:0] pitch_wide, roll_wide;
  assign pitch_wide = MA_W'(pitch_held_q);
  assign roll_wide  = MA_W'(roll_held_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q      <= BLEND_RESET;
      step_q       <= STEP_RESET;
      pitch_held_q <= '0;
      roll_held_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLEND_WEIGHT: blend_q <= cfg_wdata_i;
          CFG_STEP_TIME:    step_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.op == DP_FUSE) begin
        if (cmd_i.pitch) pitch_held_q <= sat[ANGLE_WIDTH-1:0];
        else             roll_held_q  <= sat[ANGLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        in_q   <= in_item_i;
        root_q <= '0;
      end
      DP_SQ_X: n_q <= prod[31:0];
      DP_SQ_Z: n_q <= n_q + prod[31:0];
      DP_ROOT: begin
        if (n_q >= root_sum) begin
          n_q    <= n_q - root_sum;
          root_q <= (root_q >> 1) + root_bit;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      DP_CRD_ROLL, DP_CRD_PITCH: begin
        if (cmd_i.op == DP_CRD_PITCH) roll_acc_q <= pitch_acc;
        zero_q <= (ld_x == '0) && (ld_y == '0);
        x_q    <= XW'(nx) <<< PRESHIFT;
        y_q    <= XW'(ny) <<< PRESHIFT;
        z_q    <= ld_z;
      end
      DP_CRD_ITER: begin
        if (!y_q[XW-1]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_deg(cmd_i.idx);
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_deg(cmd_i.idx);
        end
      end
      DP_MUL_RS, DP_MUL_RD, DP_MUL_WA: prod_q <= prod;
      DP_MUL_WH: wh_q <= prod;
      DP_WRITE: begin
        out_q.pitch_estimate <= pitch_wide[23:0];
        out_q.roll_estimate  <= roll_wide[23:0];
        out_q.height_out     <= in_q.baro_height;
      end
      default: ;
    endcase
  end

  assign out_item_o = out_q;

endmodule
